// ===== rtl/tcpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority ticket queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int unsigned AgeW     = 7;
  localparam int unsigned TicketW  = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register values after reset
  localparam logic [AgeW-1:0]    AgeThrReset      = 7'd60;
  localparam logic [TicketW-1:0] NormalStartReset = 16'd1;
  localparam logic [TicketW-1:0] PrefStartReset   = 16'd100;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AGE_THR      = 2'd0,
    CFG_NORMAL_START = 2'd1,
    CFG_PREF_START   = 2'd2
  } cfg_idx_e;

  // Operation codes of a request
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;     // capture the request fields
    logic exec;      // run the ring operation
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/two_class_priority_ticket_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_ticket_queue
// Strict-priority ticket queue with a normal and a preferential class.
// ----------------------------------------------------------------------------
// Each request either inserts a person (tuser = 0, tdata = age) or removes
// the next one (tuser = 1). An insert with an age at or above the threshold
// takes the next preferential ticket, otherwise the next normal ticket; a
// full ring refuses it. A remove serves the preferential ring first. Every
// request yields exactly one result: tuser holds status and class, tdata the
// ticket. The result reaches the output register through the ring access with
// a registered memory read and then the result load. The controller takes a
// new request only in the cycle after that load, so it never accepts a request
// before the last one's result is loaded. The output register lets the next
// request in while a result still waits, but the load of the next result
// stalls until the waiting one is taken. Configuration writes are taken at
// any time but are meant for an idle block; writing a ticket start reloads
// that class's ticket counter at once.
// ----------------------------------------------------------------------------
module two_class_priority_ticket_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Request stream
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [6:0] age
  input  wire logic [0:0]                    s_axis_tuser,   // [0] func
  // Result stream
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [15:0]                   m_axis_tdata,   // [15:0] ticket
  output      logic [2:0]                    m_axis_tuser,   // [1:0] status, [2] preferred
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [tcpq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tcpq_pkg::CfgDataW-1:0] cfg_data_i
);

  tcpq_pkg::cmd_t cmd;
  tcpq_pkg::sts_t sts;
  logic [1:0]     out_status;
  logic           out_pref;

  assign cfg_ready_o = 1'b1;

  tcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcpq_dp #(
    .QueueDepth (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (s_axis_tuser[0]),
    .age_i        (s_axis_tdata[tcpq_pkg::AgeW-1:0]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_ticket_o (m_axis_tdata),
    .out_status_o (out_status),
    .out_pref_o   (out_pref)
  );

  assign m_axis_tuser = {out_pref, out_status};

endmodule

`default_nettype wire

// ===== rtl/tcpq_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_ring
// Ring buffer of ticket numbers with head, tail, fill count and a
// registered read port.
// ----------------------------------------------------------------------------
module tcpq_ring #(
  parameter int unsigned Depth = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [tcpq_pkg::TicketW-1:0] push_data_i,
  input  wire logic                         pop_i,
  output      logic [tcpq_pkg::TicketW-1:0] pop_data_o,
  output      logic                         full_o,
  output      logic                         empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [tcpq_pkg::TicketW-1:0] mem [Depth];
  logic [tcpq_pkg::TicketW-1:0] rd_q;
  logic [PtrW-1:0]              head_q, head_d;
  logic [PtrW-1:0]              tail_q, tail_d;
  logic [CntW-1:0]              count_q, count_d;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = rd_q;

  // Advance pointers and the fill count
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d = (tail_q == PtrW'(Depth - 1)) ? '0 : tail_q + PtrW'(1);
    end
    if (pop_i) begin
      head_d = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_q] <= push_data_i;
    end
    if (pop_i) begin
      rd_q <= mem[head_q];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer: take a request, run it on the rings, hand the result to the
// output register.
// ----------------------------------------------------------------------------
module tcpq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire tcpq_pkg::sts_t  sts_i,
  output      tcpq_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_e;

  state_e state_q;
  logic   ready_q;

  // Decode commands from the current state, the registered ready and the status
  always_comb begin
    cmd_o          = '0;
    cmd_o.latch    = in_valid_i && ready_q;
    cmd_o.exec     = (state_q == S_EXEC);
    cmd_o.load_out = (state_q == S_RESULT) && sts_i.out_free;
  end

  assign in_ready_o = ready_q;

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && ready_q) begin
            state_q <= S_EXEC;
            ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcpq_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpq_dp
// Datapath: configuration registers, ticket counters, both rings, class
// decision and the output register.
// ----------------------------------------------------------------------------
module tcpq_dp #(
  parameter int unsigned QueueDepth = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tcpq_pkg::cmd_t                cmd_i,
  output      tcpq_pkg::sts_t                sts_o,
  input  wire logic                          func_i,
  input  wire logic [tcpq_pkg::AgeW-1:0]     age_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcpq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [tcpq_pkg::CfgDataW-1:0] cfg_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [tcpq_pkg::TicketW-1:0]  out_ticket_o,
  output      logic [1:0]                    out_status_o,
  output      logic                          out_pref_o
);

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_ISSUED,
    SRC_NORMAL,
    SRC_PREF
  } src_e;

  logic [tcpq_pkg::AgeW-1:0]    age_thr_q;
  logic [tcpq_pkg::TicketW-1:0] norm_next_q, pref_next_q;
  logic                         func_q;
  logic [tcpq_pkg::AgeW-1:0]    age_q;

  logic norm_push, norm_pop, pref_push, pref_pop;
  logic norm_full, norm_empty, pref_full, pref_empty;
  logic [tcpq_pkg::TicketW-1:0] norm_rd, pref_rd;

  logic                         is_pref;
  tcpq_pkg::status_e            res_status_d;
  tcpq_pkg::status_e            res_status_q;
  logic                         res_pref_d, res_pref_q;
  src_e                         res_src_d, res_src_q;
  logic [tcpq_pkg::TicketW-1:0] issued_q;
  logic [tcpq_pkg::TicketW-1:0] res_ticket;

  logic                         out_valid_q;
  logic [tcpq_pkg::TicketW-1:0] out_ticket_q;
  tcpq_pkg::status_e            out_status_q;
  logic                         out_pref_q;

  // Capture the request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      age_q  <= age_i;
    end
  end

  // Decide class and ring action for the held request
  always_comb begin
    is_pref      = (age_q >= age_thr_q);
    norm_push    = 1'b0;
    norm_pop     = 1'b0;
    pref_push    = 1'b0;
    pref_pop     = 1'b0;
    res_status_d = tcpq_pkg::ST_EMPTY;
    res_pref_d   = 1'b0;
    res_src_d    = SRC_NONE;
    if (func_q == tcpq_pkg::OP_INSERT) begin
      res_pref_d = is_pref;
      if (is_pref ? pref_full : norm_full) begin
        res_status_d = tcpq_pkg::ST_FULL;
      end else begin
        res_status_d = tcpq_pkg::ST_INSERTED;
        res_src_d    = SRC_ISSUED;
        pref_push    = cmd_i.exec && is_pref;
        norm_push    = cmd_i.exec && !is_pref;
      end
    end else if (!pref_empty) begin
      res_status_d = tcpq_pkg::ST_REMOVED;
      res_pref_d   = 1'b1;
      res_src_d    = SRC_PREF;
      pref_pop     = cmd_i.exec;
    end else if (!norm_empty) begin
      res_status_d = tcpq_pkg::ST_REMOVED;
      res_src_d    = SRC_NORMAL;
      norm_pop     = cmd_i.exec;
    end
  end

  tcpq_ring #(
    .Depth (QueueDepth)
  ) u_norm_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (norm_push),
    .push_data_i (norm_next_q),
    .pop_i       (norm_pop),
    .pop_data_o  (norm_rd),
    .full_o      (norm_full),
    .empty_o     (norm_empty)
  );

  tcpq_ring #(
    .Depth (QueueDepth)
  ) u_pref_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pref_push),
    .push_data_i (pref_next_q),
    .pop_i       (pref_pop),
    .pop_data_o  (pref_rd),
    .full_o      (pref_full),
    .empty_o     (pref_empty)
  );

  // Configuration registers and ticket counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_thr_q   <= tcpq_pkg::AgeThrReset;
      norm_next_q <= tcpq_pkg::NormalStartReset;
      pref_next_q <= tcpq_pkg::PrefStartReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tcpq_pkg::CFG_AGE_THR:      age_thr_q   <= cfg_data_i[tcpq_pkg::AgeW-1:0];
        tcpq_pkg::CFG_NORMAL_START: norm_next_q <= cfg_data_i[tcpq_pkg::TicketW-1:0];
        tcpq_pkg::CFG_PREF_START:   pref_next_q <= cfg_data_i[tcpq_pkg::TicketW-1:0];
        default: ;
      endcase
    end else begin
      if (norm_push) begin
        norm_next_q <= norm_next_q + tcpq_pkg::TicketW'(1);
      end
      if (pref_push) begin
        pref_next_q <= pref_next_q + tcpq_pkg::TicketW'(1);
      end
    end
  end

  // Hold the result of the executed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_src_q <= SRC_NONE;
    end else if (cmd_i.exec) begin
      res_src_q <= res_src_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_pref_q   <= res_pref_d;
      issued_q     <= is_pref ? pref_next_q : norm_next_q;
    end
  end

  // Pick the ticket source
  always_comb begin
    case (res_src_q)
      SRC_ISSUED: res_ticket = issued_q;
      SRC_NORMAL: res_ticket = norm_rd;
      SRC_PREF:   res_ticket = pref_rd;
      default:    res_ticket = '0;
    endcase
  end

  // Output register
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ticket_q <= res_ticket;
      out_status_q <= res_status_q;
      out_pref_q   <= res_pref_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_ticket_o = out_ticket_q;
  assign out_status_o = out_status_q;
  assign out_pref_o   = out_pref_q;

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a result waits");

  // At most one ring action per request
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({norm_push, norm_pop, pref_push, pref_pop}))
    else $error("more than one ring action in a cycle");

  // A normal pop only happens when the preferential ring is empty
  a_strict_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_pop |-> pref_empty)
    else $error("normal ring popped ahead of preferential ring");

  // Ring actions only in the execute step
  a_exec_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (norm_push || norm_pop || pref_push || pref_pop) |-> cmd_i.exec)
    else $error("ring touched outside the execute step");

endmodule

`default_nettype wire
